FILE: src/isd_pkg.sv
// ----------------------------------------------------------------------------
// isd_pkg
// Shared widths, register codes, reset values and status type for the IMU
// stillness detector.
// ----------------------------------------------------------------------------
package isd_pkg;

	localparam int AXES         = 6;
	localparam int ACC_AXES     = 3;
	localparam int SAMPLE_W     = 16;
	localparam int TOL_W        = 16;
	localparam int STEP_W       = 4;
	localparam int LIMIT_W      = 7;
	localparam int SCORE_W      = 8;

	// reference follows 1/SMOOTH_DIV of the error; must be a power of two
	localparam int SMOOTH_DIV   = 8;
	localparam int SMOOTH_SHIFT = $clog2(SMOOTH_DIV);

	localparam int IN_W         = AXES * SAMPLE_W;
	localparam int OUT_BITS     = 3 + SCORE_W + AXES * SAMPLE_W;
	localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8;
	localparam int REF_LSB      = 3 + SCORE_W;

	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ACC_TOL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GYR_TOL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RISE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FALL     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd4;

	localparam logic [TOL_W-1:0]   ACC_TOL_RST  = 16'd200;
	localparam logic [TOL_W-1:0]   GYR_TOL_RST  = 16'd200;
	localparam logic [STEP_W-1:0]  RISE_RST     = 4'd5;
	localparam logic [STEP_W-1:0]  FALL_RST     = 4'd3;
	localparam logic [LIMIT_W-1:0] LIMIT_RST    = 7'd100;

	typedef struct packed {
		logic                       still;
		logic                       began;
		logic                       ended;
		logic signed [SCORE_W-1:0]  score;
	} isd_status_t;

endpackage

FILE: src/isd_lane.sv
// ----------------------------------------------------------------------------
// isd_lane
// One sensor axis: reference register, tolerance check and reference update.
// ----------------------------------------------------------------------------
module isd_lane import isd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic        [TOL_W-1:0]    tol,
	input  logic                       still_next,
	output logic                       quiet,
	output logic signed [SAMPLE_W-1:0] ref_next
);

	logic signed [SAMPLE_W-1:0] ref_q;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [SAMPLE_W:0]   diff_adj;
	logic signed [SAMPLE_W:0]   step;
	logic signed [SAMPLE_W:0]   follow;
	logic        [SAMPLE_W:0]   mag;

	always_comb begin
		diff     = {sample[SAMPLE_W-1], sample} - {ref_q[SAMPLE_W-1], ref_q};
		mag      = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
		quiet    = mag < {1'b0, tol};
		// bias negatives so the shift truncates toward zero
		diff_adj = diff + (diff[SAMPLE_W] ? (SAMPLE_W+1)'(SMOOTH_DIV - 1)
			: (SAMPLE_W+1)'(0));
		step     = diff_adj >>> SMOOTH_SHIFT;
		follow   = {ref_q[SAMPLE_W-1], ref_q} + step;
		ref_next = still_next ? follow[SAMPLE_W-1:0] : sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
		end else if (load) begin
			ref_q <= ref_next;
		end
	end

endmodule

FILE: src/isd_merge.sv
// ----------------------------------------------------------------------------
// isd_merge
// Combines the lane checks into the stillness score and still flag.
// ----------------------------------------------------------------------------
module isd_merge import isd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [AXES-1:0]     quiet,
	input  logic [STEP_W-1:0]   rise,
	input  logic [STEP_W-1:0]   fall,
	input  logic [LIMIT_W-1:0]  limit,
	output logic                still_next,
	output isd_status_t         status
);

	logic signed [SCORE_W-1:0] score_q;
	logic                      still_q;
	logic signed [SCORE_W-1:0] score_next;
	logic signed [SCORE_W:0]   score_ext;
	logic signed [SCORE_W:0]   limit_ext;
	logic signed [SCORE_W:0]   sum;
	logic signed [SCORE_W:0]   sum_sat;
	logic signed [SCORE_W:0]   dif;

	always_comb begin
		score_ext  = {score_q[SCORE_W-1], score_q};
		limit_ext  = $signed((SCORE_W+1)'(limit));
		sum        = score_ext + $signed((SCORE_W+1)'(rise));
		dif        = score_ext - $signed((SCORE_W+1)'(fall));
		sum_sat    = (sum > 9'sd127) ? 9'sd127 : sum;
		score_next = score_q;
		still_next = still_q;
		if (&quiet) begin
			if (score_ext < limit_ext) begin
				score_next = sum_sat[SCORE_W-1:0];
				if (sum_sat >= limit_ext) begin
					still_next = 1'b1;
				end
			end
		end else if (score_ext > 9'sd0) begin
			score_next = dif[SCORE_W-1:0];
			if (dif <= 9'sd0) begin
				still_next = 1'b0;
			end
		end
		status.still = still_next;
		status.began = !still_q && still_next;
		status.ended = still_q && !still_next;
		status.score = score_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
			still_q <= 1'b0;
		end else if (load) begin
			score_q <= score_next;
			still_q <= still_next;
		end
	end

endmodule

FILE: src/imu_stillness_detector_core.sv
// ----------------------------------------------------------------------------
// imu_stillness_detector_core
// Six-axis IMU stillness detector: lanes check and update each axis
// reference, a merge stage keeps the stillness score and flag.
// ----------------------------------------------------------------------------
// Output: the result word is registered into the output register, or into the
// skid register while the output stalls. Throughput: one word per cycle while
// the skid register is empty; the reference and score update is combinational,
// and a two-entry output buffer keeps input ready while one result waits.
// Reset: clears references, score, still flag and buffer; registers return
// to their defaults.
module imu_stillness_detector_core import isd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// acc_x, acc_y, acc_z, gyr_x, gyr_y, gyr_z
	input  logic [IN_W-1:0]        s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// still, still_began, still_ended, score, ref_acc_x, ref_acc_y, ref_acc_z,
	// ref_gyr_x, ref_gyr_y, ref_gyr_z, zero pad
	output logic [OUT_W-1:0]       m_axis_tdata
);

	logic [TOL_W-1:0]   acc_tol_q;
	logic [TOL_W-1:0]   gyr_tol_q;
	logic [STEP_W-1:0]  rise_q;
	logic [STEP_W-1:0]  fall_q;
	logic [LIMIT_W-1:0] limit_q;

	logic                       in_acc;
	logic                       out_take;
	logic                       still_next;
	logic [AXES-1:0]            quiet;
	logic signed [SAMPLE_W-1:0] ref_next [AXES];
	isd_status_t                status;
	logic [OUT_W-1:0]           word;
	logic [OUT_W-1:0]           skid_q;
	logic                       skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_tol_q <= ACC_TOL_RST;
			gyr_tol_q <= GYR_TOL_RST;
			rise_q    <= RISE_RST;
			fall_q    <= FALL_RST;
			limit_q   <= LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ACC_TOL: acc_tol_q <= cfg_data[TOL_W-1:0];
				REG_GYR_TOL: gyr_tol_q <= cfg_data[TOL_W-1:0];
				REG_RISE:    rise_q    <= cfg_data[STEP_W-1:0];
				REG_FALL:    fall_q    <= cfg_data[STEP_W-1:0];
				REG_LIMIT:   limit_q   <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !skid_v_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_take      = m_axis_tvalid && m_axis_tready;

	for (genvar i = 0; i < AXES; i++) begin : g_lane
		isd_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.load       (in_acc),
			.sample     (s_axis_tdata[i*SAMPLE_W +: SAMPLE_W]),
			.tol        ((i < ACC_AXES) ? acc_tol_q : gyr_tol_q),
			.still_next (still_next),
			.quiet      (quiet[i]),
			.ref_next   (ref_next[i])
		);
	end

	isd_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (in_acc),
		.quiet      (quiet),
		.rise       (rise_q),
		.fall       (fall_q),
		.limit      (limit_q),
		.still_next (still_next),
		.status     (status)
	);

	always_comb begin
		word    = '0;
		word[0] = status.still;
		word[1] = status.began;
		word[2] = status.ended;
		word[3 +: SCORE_W] = status.score;
		for (int i = 0; i < AXES; i++) begin
			word[REF_LSB + i*SAMPLE_W +: SAMPLE_W] = ref_next[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			skid_v_q      <= 1'b0;
		end else if (out_take || !m_axis_tvalid) begin
			if (skid_v_q) begin
				m_axis_tvalid <= 1'b1;
				skid_v_q      <= 1'b0;
			end else begin
				m_axis_tvalid <= in_acc;
			end
		end else if (in_acc) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !m_axis_tvalid) begin
			if (skid_v_q) begin
				m_axis_tdata <= skid_q;
			end else if (in_acc) begin
				m_axis_tdata <= word;
			end
		end else if (in_acc) begin
			skid_q <= word;
		end
	end

	a_skid_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> m_axis_tvalid)
		else $error("skid word held without a head word");

	a_began_is_still: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0] && !m_axis_tdata[2])
		else $error("still_began without still");

	a_ended_is_moving: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |->
			!m_axis_tdata[0] && ($signed(m_axis_tdata[3 +: SCORE_W]) <= 0))
		else $error("still_ended with still set or positive score");

	a_full_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !m_axis_tready |=> skid_v_q && $stable(skid_q))
		else $error("skid word lost while output stalled");

endmodule

FILE: bench/imu_stillness_monitor.sv
// ----------------------------------------------------------------------------
// imu_stillness_monitor
// Watches the configuration port and both streams of the stillness detector,
// predicts each result word from its own copy of the references, score and
// registers, and compares every delivered word field by field.
// ----------------------------------------------------------------------------
module imu_stillness_monitor import isd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// acc_x, acc_y, acc_z, gyr_x, gyr_y, gyr_z
	input  logic [IN_W-1:0]       s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// still, still_began, still_ended, score, ref_acc_x .. ref_gyr_z, zero pad
	input  logic [OUT_W-1:0]      m_axis_tdata,
	output int                    fail_count,
	output int                    pending
);

	localparam int SCORE_LSB = 3;

	typedef struct packed {
		isd_status_t                         status;
		logic [AXES-1:0][SAMPLE_W-1:0]       refs;
	} detector_word_t;

	detector_word_t              awaited_results [$];
	detector_word_t              due;
	detector_word_t              fresh;

	logic signed [SAMPLE_W-1:0]  axis_ref [AXES];
	int                          score_now;
	logic                        still_now;
	int                          word_no;

	int                          acc_tol;
	int                          gyr_tol;
	int                          rise_step;
	int                          fall_step;
	int                          score_limit;

	task automatic report_error(input string msg);
		$display("monitor: word %0d: %s", word_no, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_error($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	task automatic step_detector(input logic [IN_W-1:0] word, output detector_word_t res);
		int  sample;
		int  diff;
		int  tol;
		int  moved;
		bit  quiet;
		bit  was_still;
		quiet     = 1'b1;
		was_still = still_now;
		for (int k = 0; k < AXES; k++) begin
			sample = $signed(word[k*SAMPLE_W +: SAMPLE_W]);
			diff   = sample - axis_ref[k];
			if (diff < 0)
				diff = -diff;
			tol = (k < ACC_AXES) ? acc_tol : gyr_tol;
			if (!(diff < tol))
				quiet = 1'b0;
		end
		if (quiet) begin
			if (score_now < score_limit) begin
				score_now = score_now + rise_step;
				if (score_now > 127)
					score_now = 127;
				if (score_now >= score_limit)
					still_now = 1'b1;
			end
		end else if (score_now > 0) begin
			score_now = score_now - fall_step;
			if (score_now <= 0)
				still_now = 1'b0;
		end
		for (int k = 0; k < AXES; k++) begin
			sample = $signed(word[k*SAMPLE_W +: SAMPLE_W]);
			if (still_now) begin
				moved = axis_ref[k] + (sample - axis_ref[k]) / SMOOTH_DIV;
				axis_ref[k] = moved[SAMPLE_W-1:0];
			end else begin
				axis_ref[k] = sample[SAMPLE_W-1:0];
			end
			res.refs[k] = axis_ref[k];
		end
		res.status.still = still_now;
		res.status.began = !was_still && still_now;
		res.status.ended = was_still && !still_now;
		res.status.score = score_now[SCORE_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_results.delete();
			for (int k = 0; k < AXES; k++)
				axis_ref[k] = '0;
			score_now   = 0;
			still_now   = 1'b0;
			word_no     = 0;
			acc_tol     = ACC_TOL_RST;
			gyr_tol     = GYR_TOL_RST;
			rise_step   = RISE_RST;
			fall_step   = FALL_RST;
			score_limit = LIMIT_RST;
			fail_count  = 0;
			pending     <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ACC_TOL: acc_tol     = cfg_data[TOL_W-1:0];
					REG_GYR_TOL: gyr_tol     = cfg_data[TOL_W-1:0];
					REG_RISE:    rise_step   = cfg_data[STEP_W-1:0];
					REG_FALL:    fall_step   = cfg_data[STEP_W-1:0];
					REG_LIMIT:   score_limit = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					report_error("result word with nothing outstanding");
				end else begin
					due = awaited_results.pop_front();
					check_field("still", m_axis_tdata[0], due.status.still);
					check_field("still_began", m_axis_tdata[1], due.status.began);
					check_field("still_ended", m_axis_tdata[2], due.status.ended);
					check_field("score", $signed(m_axis_tdata[SCORE_LSB +: SCORE_W]),
						$signed(due.status.score));
					for (int k = 0; k < AXES; k++)
						check_field($sformatf("reference %0d", k),
							$signed(m_axis_tdata[REF_LSB + k*SAMPLE_W +: SAMPLE_W]),
							$signed(due.refs[k]));
					check_field("pad", m_axis_tdata[OUT_W-1:OUT_BITS], 0);
				end
				word_no++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				step_detector(s_axis_tdata, fresh);
				awaited_results.push_back(fresh);
			end
			pending <= awaited_results.size();
		end
	end

endmodule

FILE: bench/imu_stillness_detector_core_test.sv
// ----------------------------------------------------------------------------
// imu_stillness_detector_core_test
// Drives the stillness detector with directed edge samples and then runs of
// jittered quiet samples, jolts and noise under a range of register settings
// and stall patterns; the monitor predicts and checks every result word.
// ----------------------------------------------------------------------------
module imu_stillness_detector_core_test import isd_pkg::*; ();

	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD   = 300;
	localparam int BATCH_WORDS = 22;
	localparam int FINAL_RUN   = 24;
	localparam int NUM_SETTINGS = 12;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SPARE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_SPARE  = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;

	int                    fail_count;
	int                    pending;
	logic                  in_taken;
	int                    idle_run;
	int                    tx_idle_pct;
	int                    rx_idle_pct;
	int                    hold_cycles;
	int                    words_sent;
	int                    cur_acc_tol;
	int                    cur_gyr_tol;

	imu_stillness_detector_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	imu_stillness_monitor i_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: cycles with no word moving anywhere
	always @(posedge clk) begin
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| cfg_wr_en)
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic push_word(input logic [IN_W-1:0] word);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		@(negedge clk);
		while (!in_taken)
			@(negedge clk);
		words_sent++;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic [15:0] acc, input logic [15:0] gyr,
			input logic [15:0] rise, input logic [15:0] fall, input logic [15:0] limit);
		write_reg(REG_ACC_TOL, acc);
		write_reg(REG_GYR_TOL, gyr);
		write_reg(REG_RISE, rise);
		write_reg(REG_FALL, fall);
		write_reg(REG_LIMIT, limit);
		// spare indices must leave every register alone
		for (int idx = REG_FIRST_SPARE; idx <= REG_LAST_SPARE; idx++)
			write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		cur_acc_tol = acc;
		cur_gyr_tol = gyr;
	endtask

	function automatic logic [IN_W-1:0] jitter(input logic [IN_W-1:0] base,
			input int acc_amp, input int gyr_amp);
		logic [IN_W-1:0] w;
		int              amp;
		for (int k = 0; k < AXES; k++) begin
			amp = (k < ACC_AXES) ? acc_amp : gyr_amp;
			w[k*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(base[k*SAMPLE_W +: SAMPLE_W]
				+ ($urandom_range(2*amp) - amp));
		end
		return w;
	endfunction

	task automatic quiet_run(input int len, input bit jolts);
		logic [IN_W-1:0] base;
		int              acc_amp;
		int              gyr_amp;
		base    = {$urandom, $urandom, $urandom};
		acc_amp = cur_acc_tol / 3;
		gyr_amp = cur_gyr_tol / 3;
		// wide jitter now and then to sit on the tolerance edge
		if ($urandom_range(3) == 0) begin
			acc_amp = cur_acc_tol;
			gyr_amp = cur_gyr_tol;
		end
		repeat (len) begin
			if (jolts && $urandom_range(19) == 0)
				push_word({$urandom, $urandom, $urandom});
			else
				push_word(jitter(base, acc_amp, gyr_amp));
		end
	endtask

	task automatic run_batch(input int target);
		int first;
		first = words_sent;
		while (words_sent - first < target) begin
			if ($urandom_range(99) < 70) begin
				quiet_run($urandom_range(5, 40), 1'b1);
			end else begin
				repeat ($urandom_range(1, 6))
					push_word({$urandom, $urandom, $urandom});
			end
		end
		quiet_run(FINAL_RUN, 1'b0);
	endtask

	initial begin
		logic [IN_W-1:0] w;
		logic [15:0]     v;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		hold_cycles   = 0;
		idle_run      = 0;
		words_sent    = 0;
		tx_idle_pct   = 27;
		rx_idle_pct   = 77;
		cur_acc_tol   = ACC_TOL_RST;
		cur_gyr_tol   = GYR_TOL_RST;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// edge samples under the reset settings
		push_word('0);
		push_word('0);
		push_word({AXES{16'h7FFF}});
		push_word({AXES{16'h8000}});
		push_word({AXES{16'h5555}});
		push_word({AXES{16'hAAAA}});
		w = {AXES{16'd1000}};
		push_word(w);
		// tolerance edges on each axis: one below passes, exactly at fails
		for (int k = 0; k < AXES; k++) begin
			v = w[k*SAMPLE_W +: SAMPLE_W];
			w[k*SAMPLE_W +: SAMPLE_W] = v + 16'(ACC_TOL_RST - 1);
			push_word(w);
			v = w[k*SAMPLE_W +: SAMPLE_W];
			w[k*SAMPLE_W +: SAMPLE_W] = v - 16'(ACC_TOL_RST);
			push_word(w);
		end

		for (int set_no = 0; set_no < NUM_SETTINGS; set_no++) begin
			drain_results();
			case (set_no)
				0: apply_setting(16'd200, 16'd200, 16'd5, 16'd3, 16'd100);
				// score saturates at the top
				1: apply_setting(16'd300, 16'd150, 16'd15, 16'd15, 16'd127);
				// limit dropped well below a held score
				2: apply_setting(16'd300, 16'd300, 16'd4, 16'd2, 16'd10);
				// nothing can be quiet
				3: apply_setting(16'd0, 16'd0, 16'd7, 16'd1, 16'd50);
				4: apply_setting(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1);
				// rise of zero, upper data bits set
				5: apply_setting(16'd1000, 16'h8001, 16'h00F0, 16'hFFF4, 16'h0F80);
				// fall of zero
				6: apply_setting(16'd400, 16'd400, 16'h1239, 16'hABC0, 16'hFFFF);
				// deep fall drives the score negative
				7: apply_setting(16'd500, 16'd40, 16'd2, 16'd15, 16'd64);
				default: apply_setting(
					($urandom_range(1) == 0) ? 16'($urandom_range(1, 3000)) : 16'($urandom),
					($urandom_range(1) == 0) ? 16'($urandom_range(1, 3000)) : 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			if (set_no < 4) begin
				tx_idle_pct = 27;
				rx_idle_pct = 77;
			end else if (set_no < 8) begin
				tx_idle_pct = 77;
				rx_idle_pct = 27;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (set_no == 2 || set_no == 10)
				hold_cycles = LONG_HOLD;
			run_batch(BATCH_WORDS);
		end

		drain_results();
		repeat (4) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
src/isd_pkg.sv
src/isd_lane.sv
src/isd_merge.sv
src/imu_stillness_detector_core.sv
bench/imu_stillness_monitor.sv
bench/imu_stillness_detector_core_test.sv
